FILE: src/wtf_pkg.sv
// Shared widths, codes, handshake structs and reset values of the trend forecaster.
`default_nettype none
package wtf_pkg;

	// Window depth default and field widths
	localparam int unsigned WINDOW_DEPTH_DEF = 256;
	localparam int unsigned SAMPLE_W         = 32;
	localparam int unsigned CNT_W            = 11;
	localparam int unsigned HOR_W            = 16;
	localparam int unsigned MIN_W            = 11;
	localparam int unsigned CLASS_W          = 2;
	localparam int unsigned PCT_W            = 7;
	localparam int unsigned CFG_IDX_W        = 2;
	localparam int unsigned CFG_DATA_W       = 16;

	// Running sum widths, sized for a window of up to 1024 samples
	localparam int unsigned SX_W  = 20;
	localparam int unsigned SXX_W = 29;
	localparam int unsigned SY_W  = 42;
	localparam int unsigned SXY_W = 52;
	localparam int unsigned S10_W = 36;
	localparam int unsigned NUM_W = 64;
	localparam int unsigned DEN_W = 40;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_HORIZON     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_SAMPLES = 2'd1;

	// Configuration reset values
	localparam logic [HOR_W-1:0] HORIZON_RST = 16'd60;
	localparam logic [MIN_W-1:0] MIN_RST     = 11'd10;

	// Trend class codes
	localparam logic [CLASS_W-1:0] CLASS_UNKNOWN    = 2'd0;
	localparam logic [CLASS_W-1:0] CLASS_STABLE     = 2'd1;
	localparam logic [CLASS_W-1:0] CLASS_INCREASING = 2'd2;
	localparam logic [CLASS_W-1:0] CLASS_DECREASING = 2'd3;

	// Thresholds in raw Q16.16 and percent caps
	localparam logic signed [SAMPLE_W-1:0] STABLE_LIMIT = 32'sd655;
	localparam logic signed [SAMPLE_W-1:0] RAPID_SLOPE  = 32'sd6554;
	localparam logic [CNT_W-1:0]           RECENT_LEN   = 11'd10;
	localparam logic [PCT_W-1:0]           PROB_CAP     = 7'd90;
	localparam logic [PCT_W-1:0]           CONF_CAP     = 7'd100;
	localparam int unsigned                FRAC_BITS    = 16;

	// Divider request and response
	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] dividend;
		logic [DEN_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [NUM_W-1:0] quotient;
	} div_rsp_t;

endpackage
`default_nettype wire

FILE: src/wtf_if.sv
// Channel interfaces of the trend forecaster: sample input, result output, config write.
`default_nettype none
interface wtf_sample_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [wtf_pkg::SAMPLE_W-1:0]   sample_value;
	modport source(output valid, output sample_value, input ready);
	modport sink(input valid, input sample_value, output ready);
endinterface

interface wtf_result_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [wtf_pkg::SAMPLE_W-1:0]   trend_slope;
	logic signed [wtf_pkg::SAMPLE_W-1:0]   forecast_value;
	logic [wtf_pkg::CLASS_W-1:0]           trend_class;
	logic [wtf_pkg::PCT_W-1:0]             confidence_percent;
	logic                                  rapid_increase;
	logic [wtf_pkg::PCT_W-1:0]             issue_probability;
	modport source(output valid, output trend_slope, output forecast_value,
		output trend_class, output confidence_percent, output rapid_increase,
		output issue_probability, input ready);
	modport sink(input valid, input trend_slope, input forecast_value,
		input trend_class, input confidence_percent, input rapid_increase,
		input issue_probability, output ready);
endinterface

interface wtf_cfg_if;
	logic                                  valid;
	logic                                  ready;
	logic [wtf_pkg::CFG_IDX_W-1:0]         index;
	logic [wtf_pkg::CFG_DATA_W-1:0]        data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: src/wtf_window_mem.sv
// Sample window storage: one write port, one registered read port.
`default_nettype none
module wtf_window_mem #(
	parameter int unsigned DEPTH = wtf_pkg::WINDOW_DEPTH_DEF,
	parameter int unsigned AW    = $clog2(wtf_pkg::WINDOW_DEPTH_DEF)
) (
	input  wire logic                              clk,
	input  wire logic                              wr_en,
	input  wire logic [AW-1:0]                     wr_addr,
	input  wire logic signed [wtf_pkg::SAMPLE_W-1:0] wr_data,
	input  wire logic                              rd_en,
	input  wire logic [AW-1:0]                     rd_addr,
	output logic signed [wtf_pkg::SAMPLE_W-1:0]    rd_data
);

	logic signed [wtf_pkg::SAMPLE_W-1:0] mem_q [DEPTH];

	// Write the new sample
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Register the read data
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

FILE: src/wtf_divider.sv
// Iterative unsigned divider, two quotient bits per cycle.
`default_nettype none
module wtf_divider (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire wtf_pkg::div_req_t req,
	output wtf_pkg::div_rsp_t      rsp
);

	localparam int unsigned NW    = wtf_pkg::NUM_W;
	localparam int unsigned DW    = wtf_pkg::DEN_W;
	localparam int unsigned STEPS = NW / 2;
	localparam int unsigned CW    = $clog2(STEPS);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] dvd_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;

	logic [DW-1:0] rem_mid;
	logic [DW-1:0] rem_end;
	logic          qb_hi;
	logic          qb_lo;

	// One restoring step: shift in a dividend bit, subtract when it fits
	function automatic logic [DW:0] div_step(input logic [DW-1:0] rem,
		input logic b, input logic [DW-1:0] den);
		logic [DW:0] r;
		logic [DW:0] d;
		r = {rem, b};
		d = {1'b0, den};
		if (r >= d) begin
			r = r - d;
			div_step = {r[DW-1:0], 1'b1};
		end else begin
			div_step = {r[DW-1:0], 1'b0};
		end
	endfunction

	// Two dependent steps per cycle
	always_comb begin
		{rem_mid, qb_hi} = div_step(rem_q, dvd_q[NW-1], den_q);
		{rem_end, qb_lo} = div_step(rem_mid, dvd_q[NW-2], den_q);
	end

	// Control: load on start, count steps down, pulse done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(STEPS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: dividend shifts out, quotient bits shift in
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			rem_q <= '0;
			den_q <= req.divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[NW-3:0], qb_hi, qb_lo};
			rem_q <= rem_end;
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = dvd_q;

endmodule
`default_nettype wire

FILE: src/windowed_trend_forecaster_core.sv
// Top level of the windowed least-squares trend forecaster.
//
//   channel     | dir | beat contents
//   ------------+-----+--------------------------------------------------------
//   sample_in   | in  | sample_value (Q16.16)
//   result_out  | out | trend_slope, forecast_value, trend_class, confidence,
//               |     | rapid_increase, issue_probability
//   cfg         | in  | index, data (0 horizon_minutes, 1 min_samples)
//
// Each sample passes from acceptance to result through two window reads, a sum
// update, two product steps, and the two-bit-per-cycle divider, which sets the
// pace. Below min_samples the second product and the divider are skipped.
// The next sample is accepted once the result sits in the output register, even
// while that result waits to be taken. Reset clears the sums, count and pointer;
// the window memory is not cleared. cfg is always ready.
`default_nettype none
module windowed_trend_forecaster_core #(
	parameter int unsigned WINDOW_DEPTH = wtf_pkg::WINDOW_DEPTH_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	wtf_sample_if.sink   sample_in,
	wtf_result_if.source result_out,
	wtf_cfg_if.sink      cfg
);

	localparam int unsigned AW  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int unsigned CW  = wtf_pkg::CNT_W;
	localparam int unsigned SW  = wtf_pkg::CNT_W + 1;
	localparam int unsigned DW  = wtf_pkg::SAMPLE_W;
	localparam int unsigned NW  = wtf_pkg::NUM_W;
	localparam int unsigned PW  = DW + wtf_pkg::HOR_W + 2;
	localparam int unsigned HW  = wtf_pkg::S10_W + CW + 1;
	localparam int unsigned BW  = DW + 10;
	localparam logic [CW-1:0] DEPTH_C = CW'(WINDOW_DEPTH);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_RD1    = 4'd1;
	localparam logic [3:0] ST_UPD    = 4'd2;
	localparam logic [3:0] ST_MUL1   = 4'd3;
	localparam logic [3:0] ST_MUL2   = 4'd4;
	localparam logic [3:0] ST_DIVSET = 4'd5;
	localparam logic [3:0] ST_DIV    = 4'd6;
	localparam logic [3:0] ST_SAT    = 4'd7;
	localparam logic [3:0] ST_FIN    = 4'd8;
	localparam logic [3:0] ST_EMIT   = 4'd9;

	logic [3:0]                     state_q;
	logic [wtf_pkg::HOR_W-1:0]      hor_q;
	logic [wtf_pkg::MIN_W-1:0]      min_q;
	logic [CW-1:0]                  count_q;
	logic [AW-1:0]                  oldest_q;
	logic [AW-1:0]                  slot_q;
	logic signed [DW-1:0]           sample_q;
	logic signed [DW-1:0]           drop_q;
	logic [wtf_pkg::SX_W-1:0]       sx_q;
	logic [wtf_pkg::SXX_W-1:0]      sxx_q;
	logic signed [wtf_pkg::SY_W-1:0]  sy_q;
	logic signed [wtf_pkg::SXY_W-1:0] sxy_q;
	logic signed [wtf_pkg::S10_W-1:0] s10_q;
	logic                           unk_q;
	logic signed [NW-1:0]           pa_q;
	logic signed [NW-1:0]           pb_q;
	logic [wtf_pkg::DEN_W-1:0]      pc_q;
	logic [wtf_pkg::DEN_W-1:0]      pd_q;
	logic                           neg_q;
	logic signed [DW-1:0]           slope_q;
	logic signed [PW-1:0]           pmul_q;
	logic signed [HW-1:0]           hmul_q;

	logic                           out_valid_q;
	logic signed [DW-1:0]           out_slope_q;
	logic signed [DW-1:0]           out_pred_q;
	logic [wtf_pkg::CLASS_W-1:0]    out_class_q;
	logic [wtf_pkg::PCT_W-1:0]      out_conf_q;
	logic                           out_rapid_q;
	logic [wtf_pkg::PCT_W-1:0]      out_prob_q;

	logic                           in_fire;
	logic                           full;
	logic [SW-1:0]                  slot_sum;
	logic [AW-1:0]                  slot_next;
	logic [SW-1:0]                  back_sum;
	logic [AW-1:0]                  back_slot;
	logic                           rd_en;
	logic [AW-1:0]                  rd_addr;
	logic signed [DW-1:0]           rd_data;

	logic [CW-1:0]                  xw;
	logic signed [CW+DW:0]          xy;
	logic [2*CW-1:0]                xx;
	logic signed [wtf_pkg::SY_W-1:0]  sy_next;
	logic signed [wtf_pkg::SXY_W-1:0] sxy_next;
	logic [CW-1:0]                  count_next;

	logic signed [NW-1:0]           num_w;
	logic [wtf_pkg::DEN_W-1:0]      den_w;
	wtf_pkg::div_req_t              div_req;
	wtf_pkg::div_rsp_t              div_rsp;

	logic                           emit_go;
	logic signed [PW:0]             pred_w;
	logic signed [DW-1:0]           pred_sat;
	logic signed [HW-1:0]           sy12;
	logic                           hot;
	logic                           rapid;
	logic signed [BW-1:0]           prod500;
	logic signed [BW-1:0]           prob_raw;
	logic [wtf_pkg::PCT_W-1:0]      prob;
	logic [wtf_pkg::CLASS_W-1:0]    cls;
	logic [wtf_pkg::PCT_W-1:0]      conf;

	assign in_fire         = sample_in.valid && sample_in.ready;
	assign sample_in.ready = (state_q == ST_IDLE);
	assign cfg.ready       = 1'b1;
	assign full            = (count_q == DEPTH_C);

	// Write slot of the new sample and slot of the sample ten back
	always_comb begin
		slot_sum = full ? SW'(oldest_q) : SW'(oldest_q) + SW'(count_q);
		if (slot_sum >= SW'(WINDOW_DEPTH)) begin
			slot_sum = slot_sum - SW'(WINDOW_DEPTH);
		end
		slot_next = slot_sum[AW-1:0];
		back_sum  = SW'(slot_q) + SW'(WINDOW_DEPTH) - SW'(wtf_pkg::RECENT_LEN);
		if (back_sum >= SW'(WINDOW_DEPTH)) begin
			back_sum = back_sum - SW'(WINDOW_DEPTH);
		end
		back_slot = back_sum[AW-1:0];
	end

	assign rd_en   = in_fire || (state_q == ST_RD1);
	assign rd_addr = (state_q == ST_IDLE) ? slot_next : back_slot;

	wtf_window_mem #(
		.DEPTH (WINDOW_DEPTH),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (state_q == ST_UPD),
		.wr_addr (slot_q),
		.wr_data (sample_q),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Sum updates for the push (and the drop when full)
	always_comb begin
		xw         = full ? DEPTH_C - 1'b1 : count_q;
		xy         = $signed({1'b0, xw}) * sample_q;
		xx         = count_q * count_q;
		count_next = full ? count_q : count_q + 1'b1;
		if (full) begin
			sy_next  = sy_q - wtf_pkg::SY_W'(drop_q) + wtf_pkg::SY_W'(sample_q);
			sxy_next = sxy_q - wtf_pkg::SXY_W'(sy_q - wtf_pkg::SY_W'(drop_q))
				+ wtf_pkg::SXY_W'(xy);
		end else begin
			sy_next  = sy_q + wtf_pkg::SY_W'(sample_q);
			sxy_next = sxy_q + wtf_pkg::SXY_W'(xy);
		end
	end

	// Numerator and denominator of the slope
	assign num_w = pa_q - pb_q;
	assign den_w = pc_q - pd_q;

	assign div_req.start    = (state_q == ST_DIVSET) && (den_w != '0);
	assign div_req.dividend = num_w[NW-1] ? NW'(-num_w) : NW'(num_w);
	assign div_req.divisor  = den_w;

	wtf_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Saturate to 32 bits
	function automatic logic signed [DW-1:0] sat_pred(input logic signed [PW:0] v);
		logic signed [PW:0] hi;
		logic signed [PW:0] lo;
		hi = (PW+1)'({1'b0, {(DW-1){1'b1}}});
		lo = -hi - 1'b1;
		if (v > hi) begin
			sat_pred = {1'b0, {(DW-1){1'b1}}};
		end else if (v < lo) begin
			sat_pred = {1'b1, {(DW-1){1'b0}}};
		end else begin
			sat_pred = v[DW-1:0];
		end
	endfunction

	// Result fields from the slope and the held products
	always_comb begin
		emit_go  = !out_valid_q || result_out.ready;
		pred_w   = (PW+1)'(sample_q) + (PW+1)'(pmul_q);
		pred_sat = sat_pred(pred_w);
		sy12     = (HW'(sy_q) <<< 3) + (HW'(sy_q) <<< 2);
		hot      = (count_q > wtf_pkg::RECENT_LEN) ? (hmul_q > sy12) : (sy_q < 0);
		rapid    = (slope_q > wtf_pkg::RAPID_SLOPE) && hot;
		prod500  = BW'(slope_q) * BW'(500);
		prob_raw = prod500 >>> wtf_pkg::FRAC_BITS;
		prob     = (prob_raw > BW'(wtf_pkg::PROB_CAP)) ? wtf_pkg::PROB_CAP
			: prob_raw[wtf_pkg::PCT_W-1:0];
		if (slope_q > wtf_pkg::STABLE_LIMIT) begin
			cls = wtf_pkg::CLASS_INCREASING;
		end else if (slope_q < -wtf_pkg::STABLE_LIMIT) begin
			cls = wtf_pkg::CLASS_DECREASING;
		end else begin
			cls = wtf_pkg::CLASS_STABLE;
		end
		conf = (count_q < CW'(wtf_pkg::CONF_CAP)) ? count_q[wtf_pkg::PCT_W-1:0]
			: wtf_pkg::CONF_CAP;
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hor_q <= wtf_pkg::HORIZON_RST;
			min_q <= wtf_pkg::MIN_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				wtf_pkg::CFG_HORIZON: begin
					hor_q <= cfg.data;
				end
				wtf_pkg::CFG_MIN_SAMPLES: begin
					min_q <= cfg.data[wtf_pkg::MIN_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Sequencer and window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			oldest_q <= '0;
			sx_q     <= '0;
			sxx_q    <= '0;
			sy_q     <= '0;
			sxy_q    <= '0;
			s10_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_RD1;
					end
				end
				ST_RD1: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (!full) begin
						sx_q  <= sx_q + wtf_pkg::SX_W'(count_q);
						sxx_q <= sxx_q + wtf_pkg::SXX_W'(xx);
					end else begin
						oldest_q <= (SW'(oldest_q) + 1'b1 == SW'(WINDOW_DEPTH)) ? '0
							: oldest_q + 1'b1;
					end
					sy_q    <= sy_next;
					sxy_q   <= sxy_next;
					count_q <= count_next;
					if (count_next <= wtf_pkg::RECENT_LEN) begin
						s10_q <= wtf_pkg::S10_W'(sy_next);
					end else begin
						s10_q <= s10_q + wtf_pkg::S10_W'(sample_q)
							- wtf_pkg::S10_W'(rd_data);
					end
					state_q <= ST_MUL1;
				end
				ST_MUL1: begin
					state_q <= (count_q < CW'(min_q)) ? ST_EMIT : ST_MUL2;
				end
				ST_MUL2: begin
					state_q <= ST_DIVSET;
				end
				ST_DIVSET: begin
					state_q <= (den_w != '0) ? ST_DIV : ST_FIN;
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						state_q <= ST_SAT;
					end
				end
				ST_SAT: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers along the sequence
	always_ff @(posedge clk) begin
		if (in_fire) begin
			sample_q <= sample_in.sample_value;
			slot_q   <= slot_next;
		end
		if (state_q == ST_RD1) begin
			drop_q <= rd_data;
		end
		if (state_q == ST_MUL1) begin
			unk_q <= (count_q < CW'(min_q));
			pa_q  <= NW'($signed({1'b0, count_q}) * sxy_q);
			pb_q  <= NW'($signed({1'b0, sx_q}) * sy_q);
		end
		if (state_q == ST_MUL2) begin
			pc_q <= wtf_pkg::DEN_W'(count_q * sxx_q);
			pd_q <= wtf_pkg::DEN_W'(sx_q * sx_q);
		end
		if (state_q == ST_DIVSET) begin
			neg_q <= num_w[NW-1];
			if (den_w == '0) begin
				slope_q <= '0;
			end
		end
		if (state_q == ST_SAT) begin
			if (!neg_q) begin
				slope_q <= (div_rsp.quotient > NW'({1'b0, {(DW-1){1'b1}}}))
					? {1'b0, {(DW-1){1'b1}}} : div_rsp.quotient[DW-1:0];
			end else begin
				slope_q <= (div_rsp.quotient > NW'({1'b1, {(DW-1){1'b0}}}))
					? {1'b1, {(DW-1){1'b0}}} : -div_rsp.quotient[DW-1:0];
			end
		end
		if (state_q == ST_FIN) begin
			pmul_q <= PW'(slope_q * $signed({1'b0, hor_q}));
			hmul_q <= HW'(s10_q * $signed({1'b0, count_q}));
		end
	end

	// Output register: load a finished result, drop it when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_EMIT) && emit_go) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_EMIT) && emit_go) begin
			if (unk_q) begin
				out_slope_q <= '0;
				out_pred_q  <= '0;
				out_class_q <= wtf_pkg::CLASS_UNKNOWN;
				out_conf_q  <= '0;
				out_rapid_q <= 1'b0;
				out_prob_q  <= '0;
			end else begin
				out_slope_q <= slope_q;
				out_pred_q  <= pred_sat;
				out_class_q <= cls;
				out_conf_q  <= conf;
				out_rapid_q <= rapid;
				out_prob_q  <= rapid ? prob : '0;
			end
		end
	end

	assign result_out.valid              = out_valid_q;
	assign result_out.trend_slope        = out_slope_q;
	assign result_out.forecast_value     = out_pred_q;
	assign result_out.trend_class        = out_class_q;
	assign result_out.confidence_percent = out_conf_q;
	assign result_out.rapid_increase     = out_rapid_q;
	assign result_out.issue_probability  = out_prob_q;

	// Fill never passes the window depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("window fill above depth");

	// Fill grows by one sample at a time
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != $past(count_q) |-> count_q == $past(count_q) + 1'b1)
		else $error("window fill jumped");

	// A probability is reported only with the flag
	a_prob_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_prob_q != '0 |-> out_rapid_q)
		else $error("probability without rapid flag");

	// Unknown results carry a zero slope
	a_unknown_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_class_q == wtf_pkg::CLASS_UNKNOWN |-> out_slope_q == '0)
		else $error("unknown result with slope");

	// The divider finishes only while the sequencer waits for it
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == ST_DIV)
		else $error("divider done outside divide wait");

endmodule
`default_nettype wire
